// ----- rtl/mtf_pkg.sv -----
// shared types and constants of the move-to-front coder
// no dependencies; every other file of the block takes names from here by scope
package mtf_pkg;

    localparam int SYMBOL_W = 8;
    localparam int APB_DATA_W = 32;
    localparam int APB_ADDR_W = 3;

    // register index, taken from paddr[2]
    localparam logic REG_DIRECTION = 1'b0;

    localparam logic DIR_ENCODE = 1'b0;
    localparam logic DIR_DECODE = 1'b1;

    // control broadcast from the row to every cell
    typedef struct packed {
        logic decode;
        logic shift;
        logic reload;
    } mtf_cell_ctrl_t;

endpackage

// ----- rtl/mtf_channels.sv -----
// valid/ready stream interfaces for the input and result channels
// depends on mtf_pkg for the symbol width
interface mtf_in_if;
    logic                         valid;
    logic                         ready;
    logic [mtf_pkg::SYMBOL_W-1:0] symbol_in;
    logic                         block_end;

    modport source (output valid, output symbol_in, output block_end, input ready);
    modport sink (input valid, input symbol_in, input block_end, output ready);
endinterface

interface mtf_out_if;
    logic                         valid;
    logic                         ready;
    logic [mtf_pkg::SYMBOL_W-1:0] symbol_out;
    logic                         end_of_block;

    modport source (output valid, output symbol_out, output end_of_block, input ready);
    modport sink (input valid, input symbol_out, input end_of_block, output ready);
endinterface

// ----- rtl/mtf_cell.sv -----
// one entry of the recency list: holds the byte at rank INDEX
// depends on mtf_pkg for the control struct
module mtf_cell #(
    parameter int          IDX_W = 8,
    parameter int unsigned INDEX = 0
) (
    input  logic                    clk,
    input  logic                    rst_n,
    input  mtf_pkg::mtf_cell_ctrl_t ctrl,
    input  logic [IDX_W-1:0]        key,
    input  logic [IDX_W-1:0]        rank,
    input  logic [IDX_W-1:0]        prev_value,
    output logic [IDX_W-1:0]        value,
    output logic [IDX_W-1:0]        tap
);

    localparam logic [IDX_W-1:0] MY_RANK = IDX_W'(INDEX);

    logic [IDX_W-1:0] value_reg;
    logic [IDX_W-1:0] value_next;
    logic             hit;

    // encode: report own rank when holding the key; decode: report value when addressed
    assign hit = (ctrl.decode == mtf_pkg::DIR_DECODE) ? (MY_RANK == key) : (value_reg == key);
    assign tap = hit ? ((ctrl.decode == mtf_pkg::DIR_DECODE) ? value_reg : MY_RANK) : '0;

    always_comb
    begin
        value_next = value_reg;
        if (ctrl.reload)
        begin
            value_next = MY_RANK;
        end
        else if (ctrl.shift && (MY_RANK <= rank))
        begin
            value_next = prev_value;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            value_reg <= MY_RANK;
        end
        else
        begin
            value_reg <= value_next;
        end
    end

    assign value = value_reg;

endmodule

// ----- rtl/mtf_row.sv -----
// row of cells forming the recency list, with the or-reduction of their taps
// depends on mtf_pkg and mtf_cell
module mtf_row #(
    parameter int ALPHABET_SIZE = 256,
    parameter int IDX_W = 8
) (
    input  logic                    clk,
    input  logic                    rst_n,
    input  mtf_pkg::mtf_cell_ctrl_t ctrl,
    input  logic [IDX_W-1:0]        key,
    output logic [IDX_W-1:0]        found,
    input  logic [IDX_W-1:0]        rank,
    input  logic [IDX_W-1:0]        front_byte,
    output logic [IDX_W-1:0]        head
);

    logic [IDX_W-1:0] values [ALPHABET_SIZE];
    logic [IDX_W-1:0] prevs  [ALPHABET_SIZE];
    logic [IDX_W-1:0] taps   [ALPHABET_SIZE];

    // the front cell takes the moved byte, every other cell its neighbor
    assign prevs[0] = front_byte;

    genvar i;
    generate
        for (i = 0; i < ALPHABET_SIZE; i++)
        begin : g_cell
            if (i > 0)
            begin : g_link
                assign prevs[i] = values[i-1];
            end
            mtf_cell #(
                .IDX_W(IDX_W),
                .INDEX(i)
            ) u_cell (
                .clk       (clk),
                .rst_n     (rst_n),
                .ctrl      (ctrl),
                .key       (key),
                .rank      (rank),
                .prev_value(prevs[i]),
                .value     (values[i]),
                .tap       (taps[i])
            );
        end
    endgenerate

    // at most one cell taps at a time, so an or collects the answer
    always_comb
    begin
        found = '0;
        for (int k = 0; k < ALPHABET_SIZE; k++)
        begin
            found = found | taps[k];
        end
    end

    assign head = values[0];

endmodule

// ----- rtl/move_to_front_coder.sv -----
// Move-to-front coder over a recency list of ALPHABET_SIZE bytes, one item per clock. Each
// transfer is coded and the list updated in the cycle it is accepted: every cell compares its
// byte against the key, an or-tree collects the rank (encode) or the byte at the rank (decode),
// and cells at or ahead of that rank shift back one place while the front cell takes the byte.
// That compare, or-tree and rank compare form the critical path. The result sits in an output
// register the cycle after acceptance; input is taken whenever that register is empty or being
// drained. block_end restores identity order after its item. Symbols at or above ALPHABET_SIZE
// pass through unchanged. direction lives at APB address 0 (0 encode, 1 decode); write it idle.
// Depends on mtf_pkg, mtf_channels, mtf_row and mtf_cell.
module move_to_front_coder #(
    parameter int ALPHABET_SIZE = 256
) (
    input  logic                           clk,
    input  logic                           rst_n,
    mtf_in_if.sink                         in_ch,
    mtf_out_if.source                      out_ch,
    input  logic                           psel,
    input  logic                           penable,
    input  logic                           pwrite,
    input  logic [mtf_pkg::APB_ADDR_W-1:0] paddr,
    input  logic [mtf_pkg::APB_DATA_W-1:0] pwdata,
    output logic [mtf_pkg::APB_DATA_W-1:0] prdata,
    output logic                           pready
);

    localparam int IDX_W = (ALPHABET_SIZE > 1) ? $clog2(ALPHABET_SIZE) : 1;

    logic                         direction_reg;
    logic                         out_valid_reg;
    logic [mtf_pkg::SYMBOL_W-1:0] out_symbol_reg;
    logic                         out_eob_reg;

    logic                         cfg_write;
    logic                         accept;
    logic                         in_range;
    logic [IDX_W-1:0]             key;
    logic [IDX_W-1:0]             found;
    logic [IDX_W-1:0]             rank;
    logic [IDX_W-1:0]             front_byte;
    logic [IDX_W-1:0]             head;
    logic [mtf_pkg::SYMBOL_W-1:0] result;
    mtf_pkg::mtf_cell_ctrl_t      ctrl;

    // configuration
    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready;
    assign prdata    = (paddr[2] == mtf_pkg::REG_DIRECTION) ?
                       mtf_pkg::APB_DATA_W'(direction_reg) : '0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            direction_reg <= mtf_pkg::DIR_ENCODE;
        end
        else if (cfg_write && (paddr[2] == mtf_pkg::REG_DIRECTION))
        begin
            direction_reg <= pwdata[0];
        end
    end

    // datapath
    assign in_ch.ready = !out_valid_reg || out_ch.ready;
    assign accept      = in_ch.valid && in_ch.ready;
    assign in_range    = ({1'b0, in_ch.symbol_in} < 9'(ALPHABET_SIZE));
    assign key         = in_ch.symbol_in[IDX_W-1:0];

    assign ctrl.decode = direction_reg;
    assign ctrl.shift  = accept && in_range;
    assign ctrl.reload = accept && in_ch.block_end;

    assign rank       = (direction_reg == mtf_pkg::DIR_DECODE) ? key : found;
    assign front_byte = (direction_reg == mtf_pkg::DIR_DECODE) ? found : key;
    assign result     = in_range ? mtf_pkg::SYMBOL_W'(found) : in_ch.symbol_in;

    mtf_row #(
        .ALPHABET_SIZE(ALPHABET_SIZE),
        .IDX_W        (IDX_W)
    ) u_row (
        .clk       (clk),
        .rst_n     (rst_n),
        .ctrl      (ctrl),
        .key       (key),
        .found     (found),
        .rank      (rank),
        .front_byte(front_byte),
        .head      (head)
    );

    // output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (accept)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ch.ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            out_symbol_reg <= result;
            out_eob_reg    <= in_ch.block_end;
        end
    end

    assign out_ch.valid        = out_valid_reg;
    assign out_ch.symbol_out   = out_symbol_reg;
    assign out_ch.end_of_block = out_eob_reg;

    // checks
    a_accept_fills_output: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> out_valid_reg)
        else $error("accepted transfer did not reach the output register");

    a_empty_output_ready: assert property (@(posedge clk) disable iff (!rst_n)
        !out_valid_reg |-> in_ch.ready)
        else $error("input stalled with an empty output register");

    a_block_end_restores_front: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && in_ch.block_end) |=> (head == '0))
        else $error("front of list not restored after end of block");

    a_front_holds_moved_byte: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && in_range && !in_ch.block_end) |=> (head == $past(front_byte)))
        else $error("coded byte did not move to the front");

endmodule
